// ----- hw/rtl/grayscale_color_tint_remap_top_defines.svh -----
// ----------------------------------------------------------------------------
// Tint remap assertion macros
// Shared concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef GRAYSCALE_COLOR_TINT_REMAP_TOP_DEFINES_SVH
`define GRAYSCALE_COLOR_TINT_REMAP_TOP_DEFINES_SVH

`ifndef ASSERT_OFF

// Property checked on every rising edge, suspended while reset is active.
`define GCTR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("gctr assertion failed");

// Property checked on every rising edge, reset included.
`define GCTR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("gctr assertion failed");

`else

`define GCTR_ASSERT(label, clk, rst_n, prop)
`define GCTR_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// ----- hw/rtl/gctr_pkg.sv -----
// ----------------------------------------------------------------------------
// Tint remap package
// Shared constants, register indexes and the per-component lane input type.
// ----------------------------------------------------------------------------
package gctr_pkg;

    // Component width and full-scale value.
    localparam int unsigned COMP_W = 8;
    localparam logic [COMP_W-1:0] FULL_SCALE = 8'hFF;

    // Number of color components handled side by side.
    localparam int unsigned NUM_COMP = 3;

    // Division pipeline: quotient bits resolved per stage and stage count.
    localparam int unsigned DIV_BITS_PER_STAGE = 2;
    localparam int unsigned NUM_DIV_STAGES = COMP_W / DIV_BITS_PER_STAGE;

    // Cycles from the accepting edge to the result strobe.
    localparam int unsigned LATENCY = NUM_DIV_STAGES + 2;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_RED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_GREEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_BLUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RED   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_GREEN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_BLUE  = 3'd5;

    // Reset value of every source and target register.
    localparam logic [COMP_W-1:0] CFG_RESET_VALUE = 8'd128;

    // What one lane needs from an item and the configuration.
    typedef struct packed {
        logic [COMP_W-1:0] comp;
        logic [COMP_W-1:0] source;
        logic [COMP_W-1:0] target;
    } t_lane_in;

endpackage

// ----- hw/rtl/gctr_lane.sv -----
// ----------------------------------------------------------------------------
// Tint remap lane
// Remaps one 8-bit component by the two-segment curve: operand select and
// multiply, a pipelined restoring divider, and the final offset add.
// ----------------------------------------------------------------------------
module gctr_lane (
    input  logic                          i_clk,
    input  gctr_pkg::t_lane_in            i_lane,
    output logic [gctr_pkg::COMP_W-1:0]   o_comp
);
    import gctr_pkg::*;

    localparam int unsigned NUM_W = 2 * COMP_W;

    // One restoring division step. The upper half holds the partial
    // remainder (always below the divisor), the lower half the dividend bits
    // still to consume, with quotient bits shifting in at the bottom.
    function automatic logic [NUM_W-1:0] div_step(
        input logic [NUM_W-1:0]  w,
        input logic [COMP_W-1:0] d
    );
        logic [COMP_W:0] trial;
        logic [COMP_W:0] diff;
        logic [NUM_W-1:0] res;
        trial = {w[NUM_W-1:COMP_W], w[COMP_W-1]};
        diff  = trial - {1'b0, d};
        if (trial >= {1'b0, d}) begin
            res = {diff[COMP_W-1:0], w[COMP_W-2:0], 1'b1};
        end else begin
            res = {trial[COMP_W-1:0], w[COMP_W-2:0], 1'b0};
        end
        return res;
    endfunction

    // Operand selection for the entry stage.
    logic                upper;
    logic [COMP_W-1:0]   mul_a;
    logic [COMP_W-1:0]   mul_b;
    logic [COMP_W-1:0]   n_div;
    logic [COMP_W-1:0]   n_off;
    logic [NUM_W-1:0]    n_num;

    always_comb begin
        upper = i_lane.comp > i_lane.source;
        if (upper) begin
            mul_a = FULL_SCALE - i_lane.target;
            mul_b = i_lane.comp - i_lane.source;
            n_div = FULL_SCALE - i_lane.source;
            n_off = i_lane.target;
        end else if (i_lane.source == '0) begin
            // Zero source and zero component: forced to a zero quotient.
            mul_a = '0;
            mul_b = '0;
            n_div = COMP_W'(1);
            n_off = '0;
        end else begin
            mul_a = i_lane.target;
            mul_b = i_lane.comp;
            n_div = i_lane.source;
            n_off = '0;
        end
        n_num = NUM_W'(mul_a) * NUM_W'(mul_b);
    end

    // Pipeline registers: index 0 is the entry stage, index k the state
    // after k division stages. The divisor is only needed up to the last
    // division stage.
    logic [NUM_W-1:0]  r_w   [NUM_DIV_STAGES+1];
    logic [COMP_W-1:0] r_div [NUM_DIV_STAGES];
    logic [COMP_W-1:0] r_off [NUM_DIV_STAGES+1];
    logic [COMP_W-1:0] r_out;

    // Entry stage captures the product, divisor and offset.
    always_ff @(posedge i_clk) begin
        r_w[0]   <= n_num;
        r_div[0] <= n_div;
        r_off[0] <= n_off;
    end

    // Each division stage resolves a fixed number of quotient bits.
    for (genvar k = 1; k <= NUM_DIV_STAGES; k++) begin : g_div
        logic [NUM_W-1:0] n_w;

        always_comb begin
            n_w = r_w[k-1];
            for (int unsigned b = 0; b < DIV_BITS_PER_STAGE; b++) begin
                n_w = div_step(n_w, r_div[k-1]);
            end
        end

        always_ff @(posedge i_clk) begin
            r_w[k]   <= n_w;
            r_off[k] <= r_off[k-1];
        end

        // Carry the divisor along to the next division stage.
        if (k < NUM_DIV_STAGES) begin : g_fwd
            always_ff @(posedge i_clk) begin
                r_div[k] <= r_div[k-1];
            end
        end
    end

    // Output stage: the quotient plus the segment offset stays within 8 bits.
    always_ff @(posedge i_clk) begin
        r_out <= r_off[NUM_DIV_STAGES] + r_w[NUM_DIV_STAGES][COMP_W-1:0];
    end

    assign o_comp = r_out;

endmodule

// ----- hw/rtl/grayscale_color_tint_remap_top.sv -----
// ----------------------------------------------------------------------------
// Grayscale color tint remap, top level
// Remaps each component of an RGB pixel by a two-segment linear curve that
// sends the source color to the target color.
// ----------------------------------------------------------------------------
//  Channel  | Ports                                        | Handshake
//  ---------+----------------------------------------------+------------------
//  pixel in | i_in_red, i_in_green, i_in_blue              | start, busy
//  pixel out| o_out_red, o_out_green, o_out_blue          | o_valid strobe
//  config   | i_cfg_idx, i_cfg_data                        | i_cfg_we
//
// One item is accepted every cycle; busy is never raised.
// Each item passes through one multiply stage, four divider stages of two
// quotient bits each, and one add stage.
// Synchronous active-low reset clears the valid pipeline and loads 128 into
// every source and target register. The receiver cannot stall the output.
// ----------------------------------------------------------------------------
`include "grayscale_color_tint_remap_top_defines.svh"

module grayscale_color_tint_remap_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [gctr_pkg::COMP_W-1:0]      i_in_red,
    input  logic [gctr_pkg::COMP_W-1:0]      i_in_green,
    input  logic [gctr_pkg::COMP_W-1:0]      i_in_blue,
    output logic                             o_valid,
    output logic [gctr_pkg::COMP_W-1:0]      o_out_red,
    output logic [gctr_pkg::COMP_W-1:0]      o_out_green,
    output logic [gctr_pkg::COMP_W-1:0]      o_out_blue,
    input  logic                             i_cfg_we,
    input  logic [gctr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gctr_pkg::COMP_W-1:0]      i_cfg_data
);
    import gctr_pkg::*;

    // The pipeline takes an item in every cycle.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // Configuration registers.
    logic [COMP_W-1:0] r_src [NUM_COMP];
    logic [COMP_W-1:0] r_tgt [NUM_COMP];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int unsigned c = 0; c < NUM_COMP; c++) begin
                r_src[c] <= CFG_RESET_VALUE;
                r_tgt[c] <= CFG_RESET_VALUE;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SOURCE_RED:   r_src[0] <= i_cfg_data;
                CFG_SOURCE_GREEN: r_src[1] <= i_cfg_data;
                CFG_SOURCE_BLUE:  r_src[2] <= i_cfg_data;
                CFG_TARGET_RED:   r_tgt[0] <= i_cfg_data;
                CFG_TARGET_GREEN: r_tgt[1] <= i_cfg_data;
                CFG_TARGET_BLUE:  r_tgt[2] <= i_cfg_data;
                default: begin
                    // Unused indexes are ignored.
                end
            endcase
        end
    end

    // Valid bits travel alongside the lane pipelines.
    logic [LATENCY-1:0] r_vld;
    logic [LATENCY-1:0] n_vld;

    assign n_vld = {r_vld[LATENCY-2:0], accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_valid = r_vld[LATENCY-1];

    // One lane per component.
    logic [COMP_W-1:0] in_comp  [NUM_COMP];
    logic [COMP_W-1:0] out_comp [NUM_COMP];

    assign in_comp[0] = i_in_red;
    assign in_comp[1] = i_in_green;
    assign in_comp[2] = i_in_blue;

    for (genvar c = 0; c < NUM_COMP; c++) begin : g_lane
        t_lane_in lane_in;

        assign lane_in.comp   = in_comp[c];
        assign lane_in.source = r_src[c];
        assign lane_in.target = r_tgt[c];

        gctr_lane u_lane (
            .i_clk  (i_clk),
            .i_lane (lane_in),
            .o_comp (out_comp[c])
        );
    end

    assign o_out_red   = out_comp[0];
    assign o_out_green = out_comp[1];
    assign o_out_blue  = out_comp[2];

    // Every accepted item yields a strobe after the fixed latency.
    `GCTR_ASSERT(a_item_to_result, i_clk, i_rst_n, accept |-> ##LATENCY o_valid)

    // No strobe without an item accepted the fixed latency earlier.
    `GCTR_ASSERT(a_result_has_item, i_clk, i_rst_n, o_valid |-> $past(accept, LATENCY))

    // Equal source and target make the red curve the identity.
    `GCTR_ASSERT(a_red_identity, i_clk, i_rst_n, (o_valid && $past(r_src[0] == r_tgt[0], LATENCY)) |-> (o_out_red == $past(i_in_red, LATENCY)))

    // A black pixel stays black whatever the configuration.
    `GCTR_ASSERT(a_black_stays, i_clk, i_rst_n, (o_valid && $past((i_in_red == '0) && (i_in_green == '0) && (i_in_blue == '0), LATENCY)) |-> ((o_out_red == '0) && (o_out_green == '0) && (o_out_blue == '0)))

    // The valid pipeline is empty right after a reset cycle.
    `GCTR_ASSERT_ALWAYS(a_reset_clears, i_clk, !$past(i_rst_n) |-> !o_valid)

endmodule
